FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl, clocked on clock and idle in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every edge
`define ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// condition that must follow from another in the same cycle
`define ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/flcv_pkg.sv
// ---------------------------------------------------------------------------
// flcv_pkg
// shared constants and types of the full linear convolution block
// ---------------------------------------------------------------------------
package flcv_pkg;

   // default sizes
   localparam int DEF_MAX_TAPS    = 32;
   localparam int DEF_SAMPLE_BITS = 16;

   // exact result width and its byte padded bus width
   localparam int RESULT_BITS = 37;
   localparam int RSP_TDATA_W = ((RESULT_BITS + 7) / 8) * 8;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // operation codes carried in tuser
   localparam logic OP_TAP    = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // control part of one queued word
   typedef struct packed {
      logic is_sample;
      logic last;
   } ctl_type;

endpackage

FILE: rtl/flcv_queue.sv
// ---------------------------------------------------------------------------
// flcv_queue
// short register queue decoupling the input side from the engine
// ---------------------------------------------------------------------------
module flcv_queue
   import flcv_pkg::*;
#(
   parameter int WIDTH = 18,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/flcv_front.sv
// ---------------------------------------------------------------------------
// flcv_front
// input side: takes words, classifies them as tap or sample and queues them
// ---------------------------------------------------------------------------
module flcv_front
   import flcv_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int TDATA_W     = ((DEF_SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [TDATA_W-1:0]            req_tdata,
   input  logic                          req_tuser,
   input  logic                          req_tlast,
   output logic                          item_valid,
   input  logic                          item_pop,
   output ctl_type                       item_ctl,
   output logic signed [SAMPLE_BITS-1:0] item_value
);

   localparam int QW = SAMPLE_BITS + $bits(ctl_type);

   logic          q_full;
   logic          push;
   ctl_type       push_ctl;
   logic [QW-1:0] push_word;
   logic [QW-1:0] pop_word;

   // classify the incoming word
   always_comb begin
      push_ctl.is_sample = (req_tuser == OP_SAMPLE);
      push_ctl.last      = req_tlast;
   end

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;
   assign push_word  = {push_ctl, req_tdata[SAMPLE_BITS-1:0]};

   flcv_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_word),
      .full      (q_full),
      .pop       (item_pop),
      .pop_data  (pop_word),
      .not_empty (item_valid)
   );

   // unpack the head of the queue
   assign item_ctl   = ctl_type'(pop_word[QW-1:SAMPLE_BITS]);
   assign item_value = $signed(pop_word[SAMPLE_BITS-1:0]);

endmodule

FILE: rtl/flcv_back.sv
// ---------------------------------------------------------------------------
// flcv_back
// engine: tap store, sample history, serial multiply accumulate and result
// register; flushes the tail after the last sample
// ---------------------------------------------------------------------------
module flcv_back
   import flcv_pkg::*;
#(
   parameter int MAX_TAPS    = DEF_MAX_TAPS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   output logic                          item_pop,
   input  ctl_type                       item_ctl,
   input  logic signed [SAMPLE_BITS-1:0] item_value,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RESULT_BITS-1:0]        rsp_result,
   output logic                          rsp_tlast
);

   localparam int AW         = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CW         = $clog2(MAX_TAPS + 1);
   localparam int HIST_DEPTH = 2 ** AW;
   localparam int PW         = 2 * SAMPLE_BITS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MAC  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   // storage
   logic signed [SAMPLE_BITS-1:0] tap_mem  [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];

   // control state
   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] tap_count_ff, tap_count_in;
   logic          set_closed_ff, set_closed_in;
   logic [AW-1:0] newest_ff, newest_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          is_last_ff, is_last_in;
   logic [CW-1:0] tail_ff, tail_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          rd_vld_ff, prod_vld_ff;
   logic          out_vld_ff, out_vld_in;

   // datapath
   logic signed [SAMPLE_BITS-1:0] tap_rd_ff, hist_rd_ff;
   logic                          hist_ok_ff;
   logic signed [PW-1:0]          prod_ff;
   logic [RESULT_BITS-1:0]        acc_ff, acc_in;
   logic [RESULT_BITS-1:0]        out_data_ff, out_data_in;
   logic                          out_last_ff, out_last_in;

   // write strobes and shared signals
   logic                          tap_we;
   logic [CW-1:0]                 tap_waddr;
   logic                          hist_we;
   logic signed [SAMPLE_BITS-1:0] hist_wdata;
   logic                          issue;
   logic                          out_free;
   logic [CW-1:0]                 tail_next;
   logic [CW-1:0]                 fill_next;

   assign item_pop  = (state_ff == ST_IDLE) && item_valid;
   assign issue     = (state_ff == ST_MAC) && (idx_ff < tap_count_ff);
   assign out_free  = !out_vld_ff || rsp_tready;
   assign tail_next = tail_ff + CW'(1);
   assign fill_next = (fill_ff < CW'(MAX_TAPS)) ? fill_ff + CW'(1) : fill_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      tap_count_in  = tap_count_ff;
      set_closed_in = set_closed_ff;
      newest_in     = newest_ff;
      fill_in       = fill_ff;
      is_last_in    = is_last_ff;
      tail_in       = tail_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      out_vld_in    = out_vld_ff && !rsp_tready;
      out_data_in   = out_data_ff;
      out_last_in   = out_last_ff;
      tap_we        = 1'b0;
      tap_waddr     = set_closed_ff ? '0 : tap_count_ff;
      hist_we       = 1'b0;
      hist_wdata    = item_value;

      if (prod_vld_ff) begin
         acc_in = acc_ff + RESULT_BITS'(prod_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               if (item_ctl.is_sample) begin
                  // shift the sample into the history
                  hist_we    = 1'b1;
                  newest_in  = newest_ff + AW'(1);
                  fill_in    = fill_next;
                  is_last_in = item_ctl.last;
                  tail_in    = '0;
                  idx_in     = '0;
                  acc_in     = '0;
                  state_in   = ST_MAC;
               end else begin
                  // tap load, a closed set restarts at entry zero
                  tap_count_in  = tap_waddr;
                  set_closed_in = 1'b0;
                  if (tap_waddr < CW'(MAX_TAPS)) begin
                     tap_we       = 1'b1;
                     tap_count_in = tap_waddr + CW'(1);
                  end
                  if (item_ctl.last) begin
                     set_closed_in = 1'b1;
                  end
               end
            end
         end
         ST_MAC: begin
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end else if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               out_vld_in  = 1'b1;
               out_data_in = acc_ff;
               out_last_in = is_last_ff && (tail_next >= tap_count_ff);
               if (is_last_ff && (tail_next < tap_count_ff)) begin
                  // tail output: shift a zero in and run again
                  hist_we    = 1'b1;
                  hist_wdata = '0;
                  newest_in  = newest_ff + AW'(1);
                  fill_in    = fill_next;
                  tail_in    = tail_next;
                  idx_in     = '0;
                  acc_in     = '0;
                  state_in   = ST_MAC;
               end else begin
                  if (is_last_ff) begin
                     fill_in = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tap_count_ff  <= '0;
         set_closed_ff <= 1'b1;
         newest_ff     <= '0;
         fill_ff       <= '0;
         is_last_ff    <= 1'b0;
         tail_ff       <= '0;
         idx_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         prod_vld_ff   <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tap_count_ff  <= tap_count_in;
         set_closed_ff <= set_closed_in;
         newest_ff     <= newest_in;
         fill_ff       <= fill_in;
         is_last_ff    <= is_last_in;
         tail_ff       <= tail_in;
         idx_ff        <= idx_in;
         rd_vld_ff     <= issue;
         prod_vld_ff   <= rd_vld_ff;
         out_vld_ff    <= out_vld_in;
      end
   end

   // memories: one write, one registered read each
   always_ff @(posedge clock) begin
      if (tap_we) begin
         tap_mem[tap_waddr[AW-1:0]] <= item_value;
      end
      if (hist_we) begin
         hist_mem[newest_ff + AW'(1)] <= hist_wdata;
      end
      tap_rd_ff  <= tap_mem[idx_ff[AW-1:0]];
      hist_rd_ff <= hist_mem[newest_ff - idx_ff[AW-1:0]];
      hist_ok_ff <= (idx_ff < fill_ff);
   end

   // product, accumulator and result register
   always_ff @(posedge clock) begin
      prod_ff     <= hist_ok_ff ? tap_rd_ff * hist_rd_ff : $signed(PW'(0));
      acc_ff      <= acc_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_result = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   `include "assert_macros.svh"

   `ASSERT_ALWAYS(a_fill_bound, fill_ff <= CW'(MAX_TAPS), "history fill count overran")
   `ASSERT_ALWAYS(a_tap_bound, tap_count_ff <= CW'(MAX_TAPS), "tap count overran")
   `ASSERT_IMPLY(a_idle_drained, state_ff == ST_IDLE, !rd_vld_ff && !prod_vld_ff, "busy in idle")
   `ASSERT_IMPLY(a_tail_bound, state_ff == ST_MAC, tail_ff < CW'(MAX_TAPS), "tail count overran")

endmodule

FILE: rtl/full_linear_convolution_top.sv
// latency: a sample word's result passes the history write, the tap walk, the read, product
// and accumulator registers and the result register; each tail word after the last sample runs the walk again
// throughput: one tap word per cycle while the engine is idle; the engine takes no new word until
// a sample's result and tail are out, as the single multiply accumulate unit walks the tap store one entry a cycle
// reset: synchronous; clears control, the tap count and the history fill count, so
// history and tap contents read as empty without a clearing pass
// ---------------------------------------------------------------------------
// full_linear_convolution_top
// full linear convolution as a streaming fir: tap words load the impulse
// response, sample words give one output each, the last sample flushes the tail
// ---------------------------------------------------------------------------
module full_linear_convolution_top
   import flcv_pkg::*;
#(
   parameter int MAX_TAPS    = DEF_MAX_TAPS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [TDATA_W-1:0]     req_tdata,  // [SAMPLE_BITS-1:0] sample_value
   input  logic                   req_tuser,  // [0] operation
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [36:0] result_value
   output logic                   rsp_tlast
);

   logic                          item_valid;
   logic                          item_pop;
   ctl_type                       item_ctl;
   logic signed [SAMPLE_BITS-1:0] item_value;
   logic [RESULT_BITS-1:0]        rsp_result;

   flcv_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TDATA_W     (TDATA_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item_ctl   (item_ctl),
      .item_value (item_value)
   );

   flcv_back #(
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item_ctl   (item_ctl),
      .item_value (item_value),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result),
      .rsp_tlast  (rsp_tlast)
   );

   // zero pad the result to whole bytes
   assign rsp_tdata = {(RSP_TDATA_W - RESULT_BITS)'(0), rsp_result};

endmodule

FILE: test/full_linear_convolution_top_tb.sv
// ---------------------------------------------------------------------------
// full_linear_convolution_top_tb
// self-checking bench for the streaming full linear convolution block: tap
// and sample words go in on the request stream, and a predictor with its own
// tap store and delay line works out every expected output word; results are
// compared in order on the response stream while both sides idle and stall
// ---------------------------------------------------------------------------
module full_linear_convolution_top_tb;
   import flcv_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  NTAPS       = DEF_MAX_TAPS;
   localparam int  SBITS       = DEF_SAMPLE_BITS;
   localparam int  ITEM_TARGET = 400;
   localparam int  CYCLE_LIMIT = 5000000;
   localparam int  DRAIN_WAIT  = 4 * (NTAPS + 5);
   localparam int  HOLD_CYCLES = 1500;
   localparam int  HOLD_AT     = 50;

   typedef struct packed {
      logic             op;
      logic [SBITS-1:0] value;
      logic             last;
   } conv_word_type;

   typedef struct packed {
      logic [RESULT_BITS-1:0] value;
      logic                   last;
   } conv_out_type;

   // dut ports
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SBITS-1:0]       req_tdata  = '0;  // [15:0] sample_value
   logic                   req_tuser  = 1'b0; // [0] operation
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // [36:0] result_value
   logic                   rsp_tlast;

   // stimulus and expected outputs
   conv_word_type words_to_send[$];
   conv_out_type  conv_expected[$];

   // predictor state
   logic signed [SBITS-1:0] pred_taps [NTAPS];
   logic signed [SBITS-1:0] pred_delay[NTAPS];
   int unsigned             pred_tap_count = 0;
   bit                      pred_set_closed = 1'b1;

   // bookkeeping
   int  error_count    = 0;
   int  accepted_words = 0;
   int  total_words    = 0;
   int  taps_sent      = 0;
   int  samples_sent   = 0;
   int  signals_sent   = 0;
   int  outputs_seen   = 0;
   int  cycle_count    = 0;
   int  hold_left      = 0;
   bit  hold_done      = 1'b0;
   bit  req_taken      = 1'b0;

   full_linear_convolution_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // exact fir sum over the loaded taps, cut to the result width
   function automatic logic [RESULT_BITS-1:0] fir_output();
      logic signed [63:0] acc;
      acc = '0;
      for (int i = 0; i < pred_tap_count && i < NTAPS; i++) begin
         acc = acc + pred_taps[i] * pred_delay[i];
      end
      return acc[RESULT_BITS-1:0];
   endfunction

   function automatic void shift_delay(logic signed [SBITS-1:0] v);
      for (int i = NTAPS - 1; i > 0; i--) pred_delay[i] = pred_delay[i-1];
      pred_delay[0] = v;
   endfunction

   // predict the outputs of one accepted word
   function automatic void predict_convolution(conv_word_type w);
      conv_out_type o;
      if (w.op == OP_TAP) begin
         if (pred_set_closed) begin
            foreach (pred_taps[i]) pred_taps[i] = '0;
            pred_tap_count  = 0;
            pred_set_closed = 1'b0;
         end
         if (pred_tap_count < NTAPS) begin
            pred_taps[pred_tap_count] = w.value;
            pred_tap_count++;
         end
         if (w.last) pred_set_closed = 1'b1;
      end else begin
         shift_delay(w.value);
         o.value = fir_output();
         o.last  = w.last && (pred_tap_count <= 1);
         conv_expected = {conv_expected, o};
         if (w.last) begin
            // flush the tail, then clear the delay line
            for (int t = 1; t < pred_tap_count && t < NTAPS; t++) begin
               shift_delay('0);
               o.value = fir_output();
               o.last  = (t + 1 == pred_tap_count);
               conv_expected = {conv_expected, o};
            end
            foreach (pred_delay[i]) pred_delay[i] = '0;
         end
      end
   endfunction

   function automatic void queue_word(logic op, logic [SBITS-1:0] v, logic last);
      conv_word_type w;
      w.op    = op;
      w.value = v;
      w.last  = last;
      words_to_send = {words_to_send, w};
      if (op == OP_TAP) taps_sent++;
      else begin
         samples_sent++;
         if (last) signals_sent++;
      end
   endfunction

   // random value, leaning on the extremes now and then
   function automatic logic [SBITS-1:0] pick_value();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void queue_tap_set(int len);
      for (int i = 0; i < len; i++) queue_word(OP_TAP, pick_value(), i == len - 1);
   endfunction

   function automatic int pick_set_length();
      int r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(8, 1);
      if (r < 93) return $urandom_range(32, 9);
      return $urandom_range(36, 33);
   endfunction

   // idle percentages by phase of the run
   function automatic int sender_idle_pct();
      if (accepted_words < total_words / 3) return 38;
      if (accepted_words < 2 * total_words / 3) return 74;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (accepted_words < total_words / 3) return 74;
      if (accepted_words < 2 * total_words / 3) return 38;
      return 0;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (words_to_send.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
            conv_word_type w;
            w = words_to_send.pop_front();
            req_tdata  <= w.value;
            req_tuser  <= w.op;
            req_tlast  <= w.last;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!hold_done && accepted_words >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   // prediction on accepted words, checking on accepted results
   always @(posedge clock) begin
      conv_word_type w;
      conv_out_type  exp_out;
      req_taken <= req_tvalid && req_tready && !reset;
      if (!reset && req_tvalid && req_tready) begin
         w.op    = req_tuser;
         w.value = req_tdata;
         w.last  = req_tlast;
         predict_convolution(w);
         accepted_words++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         outputs_seen++;
         if (conv_expected.size() == 0) begin
            $error("unexpected output word: result_value %0d, last_result %0b",
                   $signed(rsp_tdata[RESULT_BITS-1:0]), rsp_tlast);
            error_count++;
         end else begin
            exp_out = conv_expected.pop_front();
            if (rsp_tdata[RESULT_BITS-1:0] !== exp_out.value) begin
               $error("result_value: expected %0d, got %0d",
                      $signed(exp_out.value), $signed(rsp_tdata[RESULT_BITS-1:0]));
               error_count++;
            end
            if (rsp_tlast !== exp_out.last) begin
               $error("last_result: expected %0b, got %0b", exp_out.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** full_linear_convolution_top: FAILED **");
      $finish;
   end

   // stimulus and end of run
   initial begin
      int n_sig;
      foreach (pred_taps[i]) pred_taps[i] = '0;
      foreach (pred_delay[i]) pred_delay[i] = '0;

      // no taps loaded: zero outputs, the last one flagged, no tail
      queue_word(OP_SAMPLE, 16'h0064, 1'b0);
      queue_word(OP_SAMPLE, 16'h8000, 1'b1);
      // single tap at the negative extreme
      queue_word(OP_TAP,    16'h8000, 1'b1);
      queue_word(OP_SAMPLE, 16'h8000, 1'b0);
      queue_word(OP_SAMPLE, 16'h7fff, 1'b1);
      // samples while the set is still open, more taps loaded mid-signal
      queue_word(OP_TAP,    16'h7fff, 1'b0);
      queue_word(OP_SAMPLE, 16'h7fff, 1'b0);
      queue_word(OP_TAP,    16'hffff, 1'b0);
      queue_word(OP_SAMPLE, 16'h8000, 1'b0);
      queue_word(OP_TAP,    16'h8000, 1'b1);
      queue_word(OP_SAMPLE, 16'h7fff, 1'b0);
      queue_word(OP_SAMPLE, 16'h0000, 1'b1);
      // four tap set, all extremes, short signal with tail
      queue_word(OP_TAP,    16'h8000, 1'b0);
      queue_word(OP_TAP,    16'h8000, 1'b0);
      queue_word(OP_TAP,    16'h7fff, 1'b0);
      queue_word(OP_TAP,    16'h8000, 1'b1);
      queue_word(OP_SAMPLE, 16'h8000, 1'b0);
      queue_word(OP_SAMPLE, 16'h8000, 1'b0);
      queue_word(OP_SAMPLE, 16'h8000, 1'b1);

      // overflowing tap set: the extra taps are dropped, the last still closes it
      queue_tap_set(34);
      for (int i = 0; i < 3; i++) queue_word(OP_SAMPLE, pick_value(), i == 2);

      // random part: mostly whole tap sets and signals, some noise
      while (words_to_send.size() < ITEM_TARGET) begin
         if ($urandom_range(99) < 85) begin
            if ($urandom_range(99) < 70) queue_tap_set(pick_set_length());
            n_sig = $urandom_range(12, 1);
            for (int i = 0; i < n_sig; i++) begin
               if ($urandom_range(99) < 5)
                  queue_word(OP_TAP, pick_value(), 1'($urandom_range(1)));
               queue_word(OP_SAMPLE, pick_value(), i == n_sig - 1);
            end
         end else begin
            repeat ($urandom_range(3, 1))
               queue_word(1'($urandom_range(1)), pick_value(), 1'($urandom_range(1)));
         end
      end
      total_words = words_to_send.size();

      // reset
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for every word to go in and every result to come out
      while (words_to_send.size() > 0 || req_tvalid) @(posedge clock);
      while (conv_expected.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("run covered %0d words: %0d taps, %0d samples in %0d signals",
               total_words, taps_sent, samples_sent, signals_sent);
      $display("%0d output words checked over %0d cycles, %0d mismatches",
               outputs_seen, cycle_count, error_count);
      if (error_count == 0 && conv_expected.size() == 0) begin
         $display("** full_linear_convolution_top: PASSED **");
      end else begin
         $display("** full_linear_convolution_top: FAILED **");
      end
      $finish;
   end

endmodule
